@@ sv/obm_pkg.sv @@
`timescale 1ns / 1ps

package obm_pkg;

    localparam int BOOK_DEPTH = 16;
    // Entry index and fill count widths
    localparam int AW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
    localparam int CW = $clog2(BOOK_DEPTH + 1);
    localparam int ENTRY_W = 48;

    typedef enum logic [1:0] {
        KIND_TRADE   = 2'd0,
        KIND_FILLED  = 2'd1,
        KIND_RESTED  = 2'd2,
        KIND_DROPPED = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0]  trader;
        logic [7:0]  item;
        logic [15:0] price;
        logic [15:0] qty;
    } t_entry;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  seller;
        logic [7:0]  buyer;
        logic [7:0]  item;
        logic [15:0] price;
        logic [15:0] qty;
        logic        last;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_WALK   = 3'b010,
        S_STATUS = 3'b100
    } t_state;

endpackage

@@ sv/obm_ram.sv @@
`timescale 1ns / 1ps

module obm_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 48,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

@@ sv/obm_out_reg.sv @@
`timescale 1ns / 1ps

module obm_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  obm_pkg::t_result i_word,
    output logic             o_busy,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_seller_id,
    output logic [7:0]       o_buyer_id,
    output logic [7:0]       o_trade_item,
    output logic [15:0]      o_trade_price,
    output logic [15:0]      o_trade_quantity,
    output logic             o_last
);
    import obm_pkg::*;

    logic    r_valid;
    t_result r_word;

    // a push only comes while not busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_word <= i_word;
        end
    end

    assign o_busy           = r_valid && !i_ready;
    assign o_valid          = r_valid;
    assign o_kind           = r_word.kind;
    assign o_seller_id      = r_word.seller;
    assign o_buyer_id       = r_word.buyer;
    assign o_trade_item     = r_word.item;
    assign o_trade_price    = r_word.price;
    assign o_trade_quantity = r_word.qty;
    assign o_last           = r_word.last;

endmodule

@@ sv/order_book_matching_unit.sv @@
`timescale 1ns / 1ps

// Limit order matching: one order word in, then zero or more trade words and
// one closing status word (o_last high) out. Both books sit in single-port-
// read RAMs; an order streams the opposite book through a read/modify/write
// pass, one resting entry per cycle while no trade word is held up by the
// output side, compacting out used-up entries as it goes. The status word
// follows the walk, and the next order word can be taken once the status
// word has been handed to the output register. A trade or status word that
// finds the previous word still held by the output side waits for it.
// New orders are taken only between orders.
module order_book_matching_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [7:0]  i_trader_id,
    input  logic [7:0]  i_item_id,
    input  logic [15:0] i_limit_price,
    input  logic [15:0] i_order_quantity,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_seller_id,
    output logic [7:0]  o_buyer_id,
    output logic [7:0]  o_trade_item,
    output logic [15:0] o_trade_price,
    output logic [15:0] o_trade_quantity,
    output logic        o_last
);
    import obm_pkg::*;

    t_state      r_state;
    logic        r_is_buy;
    logic [7:0]  r_trader;
    logic [7:0]  r_item;
    logic [15:0] r_limit;
    logic [15:0] r_remain;
    logic [CW-1:0] r_buy_cnt, r_sell_cnt;
    logic [CW-1:0] r_rd, r_wr;   // read and compacted write pointers
    logic        r_dv;           // RAM output holds entry r_rd-1

    logic [ENTRY_W-1:0] buy_rdata, sell_rdata;
    logic        buy_we, sell_we, buy_re, sell_re;
    logic [AW-1:0] buy_waddr, sell_waddr;
    logic [ENTRY_W-1:0] buy_wdata, sell_wdata;

    logic [CW-1:0] walk_cnt, own_cnt;
    t_entry      e, walk_wdata, own_entry;
    logic        crossed, hit, go, out_busy, push;
    logic        walk_we, walk_re, own_we;
    logic [15:0] fill, left_qty;
    t_result     word;

    assign walk_cnt = r_is_buy ? r_sell_cnt : r_buy_cnt;
    assign own_cnt  = r_is_buy ? r_buy_cnt : r_sell_cnt;
    assign e        = t_entry'(r_is_buy ? sell_rdata : buy_rdata);

    // match test on the entry just read
    assign crossed  = r_is_buy ? (e.price <= r_limit) : (e.price >= r_limit);
    assign hit      = (r_state == S_WALK) && r_dv && (r_remain != 16'd0) &&
                      (e.trader != r_trader) && (e.item == r_item) && crossed;
    assign fill     = (e.qty < r_remain) ? e.qty : r_remain;
    assign left_qty = e.qty - fill;
    assign go       = !(hit && out_busy);

    // entries survive at the write pointer unless used up
    assign walk_we  = (r_state == S_WALK) && go && r_dv && (!hit || (left_qty != 16'd0));
    assign walk_re  = (r_state == S_WALK) && go && (r_rd < walk_cnt);
    always_comb begin
        walk_wdata = e;
        if (hit) begin
            walk_wdata.qty = left_qty;
        end
    end

    assign own_we    = (r_state == S_STATUS) && !out_busy && (r_remain != 16'd0) &&
                       (own_cnt < CW'(BOOK_DEPTH));
    assign own_entry = '{trader: r_trader, item: r_item, price: r_limit, qty: r_remain};

    // route walk and rest traffic to the two books
    assign buy_we     = r_is_buy ? own_we : walk_we;
    assign buy_waddr  = r_is_buy ? own_cnt[AW-1:0] : r_wr[AW-1:0];
    assign buy_wdata  = r_is_buy ? ENTRY_W'(own_entry) : ENTRY_W'(walk_wdata);
    assign buy_re     = !r_is_buy && walk_re;
    assign sell_we    = r_is_buy ? walk_we : own_we;
    assign sell_waddr = r_is_buy ? r_wr[AW-1:0] : own_cnt[AW-1:0];
    assign sell_wdata = r_is_buy ? ENTRY_W'(walk_wdata) : ENTRY_W'(own_entry);
    assign sell_re    = r_is_buy && walk_re;

    obm_ram #(.DEPTH(BOOK_DEPTH), .WIDTH(ENTRY_W), .AW(AW)) u_buy_ram (
        .i_clk(i_clk), .i_we(buy_we), .i_waddr(buy_waddr), .i_wdata(buy_wdata),
        .i_re(buy_re), .i_raddr(r_rd[AW-1:0]), .o_rdata(buy_rdata)
    );

    obm_ram #(.DEPTH(BOOK_DEPTH), .WIDTH(ENTRY_W), .AW(AW)) u_sell_ram (
        .i_clk(i_clk), .i_we(sell_we), .i_waddr(sell_waddr), .i_wdata(sell_wdata),
        .i_re(sell_re), .i_raddr(r_rd[AW-1:0]), .o_rdata(sell_rdata)
    );

    // result word: trade during the walk, status at the end
    assign push = hit ? go : ((r_state == S_STATUS) && !out_busy);
    always_comb begin
        if (r_state == S_WALK) begin
            word.kind   = KIND_TRADE;
            word.seller = r_is_buy ? e.trader : r_trader;
            word.buyer  = r_is_buy ? r_trader : e.trader;
            word.price  = e.price;
            word.qty    = fill;
            word.last   = 1'b0;
        end else begin
            if (r_remain == 16'd0) begin
                word.kind = KIND_FILLED;
            end else if (own_cnt < CW'(BOOK_DEPTH)) begin
                word.kind = KIND_RESTED;
            end else begin
                word.kind = KIND_DROPPED;
            end
            word.seller = r_trader;
            word.buyer  = 8'd0;
            word.price  = r_limit;
            word.qty    = r_remain;
            word.last   = 1'b1;
        end
        word.item = r_item;
    end

    obm_out_reg u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_word(word),
        .o_busy(out_busy), .o_valid(o_valid), .i_ready(i_ready),
        .o_kind(o_kind), .o_seller_id(o_seller_id), .o_buyer_id(o_buyer_id),
        .o_trade_item(o_trade_item), .o_trade_price(o_trade_price),
        .o_trade_quantity(o_trade_quantity), .o_last(o_last)
    );

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_buy_cnt  <= '0;
            r_sell_cnt <= '0;
            r_dv       <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_WALK;
                        r_dv    <= 1'b0;
                    end
                end
                S_WALK: begin
                    if (go) begin
                        r_dv <= walk_re;
                    end
                    // pass complete: the book shrinks to the compacted count
                    if (!r_dv && (r_rd == walk_cnt)) begin
                        if (r_is_buy) begin
                            r_sell_cnt <= r_wr;
                        end else begin
                            r_buy_cnt <= r_wr;
                        end
                        r_state <= S_STATUS;
                    end
                end
                S_STATUS: begin
                    if (!out_busy) begin
                        if (own_we) begin
                            if (r_is_buy) begin
                                r_buy_cnt <= r_buy_cnt + 1'b1;
                            end else begin
                                r_sell_cnt <= r_sell_cnt + 1'b1;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // order word and walk pointers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_is_buy <= i_command;
            r_trader <= i_trader_id;
            r_item   <= i_item_id;
            r_limit  <= i_limit_price;
            r_remain <= i_order_quantity;
            r_rd     <= '0;
            r_wr     <= '0;
        end else begin
            if (walk_we) begin
                r_wr <= r_wr + 1'b1;
            end
            if (walk_re) begin
                r_rd <= r_rd + 1'b1;
            end
            if (hit && go) begin
                r_remain <= r_remain - fill;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_buy_cnt <= CW'(BOOK_DEPTH)) && (r_sell_cnt <= CW'(BOOK_DEPTH)))
        else $error("book count beyond depth");
    a_wr_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_wr <= r_rd))
        else $error("compaction pointer overtook read pointer");
    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && word.last |-> (r_state == S_STATUS))
        else $error("status word outside status state");
    a_no_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !out_busy)
        else $error("word pushed over a stalled word");
`endif

endmodule

@@ tb/sv/obm_checker.sv @@
`timescale 1ns / 1ps

module obm_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic        i_command,
    input  logic [7:0]  i_trader_id,
    input  logic [7:0]  i_item_id,
    input  logic [15:0] i_limit_price,
    input  logic [15:0] i_order_quantity,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [1:0]  o_kind,
    input  logic [7:0]  o_seller_id,
    input  logic [7:0]  o_buyer_id,
    input  logic [7:0]  o_trade_item,
    input  logic [15:0] o_trade_price,
    input  logic [15:0] o_trade_quantity,
    input  logic        o_last,
    output int          fail_count,
    output int          pending_words
);
    import obm_pkg::*;

    t_entry  mdl_buys[$];
    t_entry  mdl_sells[$];
    t_result due_words[$];

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    // Matches one order against the opposite book and queues its words.
    task automatic match_order(input logic is_buy, input logic [7:0] trader,
                               input logic [7:0] item, input logic [15:0] limit,
                               input logic [15:0] qty);
        t_entry  e;
        t_result r;
        logic [15:0] remain;
        logic [15:0] fill;
        logic crosses;
        int i;
        remain = qty;
        i = 0;
        while (remain != 0 && i < (is_buy ? mdl_sells.size() : mdl_buys.size())) begin
            e = is_buy ? mdl_sells[i] : mdl_buys[i];
            crosses = is_buy ? (e.price <= limit) : (e.price >= limit);
            if (e.trader == trader || e.item != item || !crosses) begin
                i++;
                continue;
            end
            fill = (e.qty < remain) ? e.qty : remain;
            r.kind   = KIND_TRADE;
            r.seller = is_buy ? e.trader : trader;
            r.buyer  = is_buy ? trader : e.trader;
            r.item   = item;
            r.price  = e.price;
            r.qty    = fill;
            r.last   = 1'b0;
            due_words.push_back(r);
            remain -= fill;
            e.qty -= fill;
            if (e.qty == 0) begin
                if (is_buy) mdl_sells.delete(i);
                else mdl_buys.delete(i);
            end else begin
                if (is_buy) mdl_sells[i] = e;
                else mdl_buys[i] = e;
                i++;
            end
        end
        r.seller = trader;
        r.buyer  = 8'd0;
        r.item   = item;
        r.price  = limit;
        r.last   = 1'b1;
        r.qty    = remain;
        if (remain == 0) begin
            r.kind = KIND_FILLED;
        end else if ((is_buy ? mdl_buys.size() : mdl_sells.size()) < BOOK_DEPTH) begin
            r.kind = KIND_RESTED;
            e.trader = trader;
            e.item   = item;
            e.price  = limit;
            e.qty    = remain;
            if (is_buy) mdl_buys.push_back(e);
            else mdl_sells.push_back(e);
        end else begin
            r.kind = KIND_DROPPED;
        end
        due_words.push_back(r);
    endtask

    initial begin
        fail_count = 0;
        pending_words = 0;
    end

    always @(posedge i_clk) begin
        t_result x;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (due_words.size() == 0) begin
                    report_mismatch("result word with none expected");
                end else begin
                    x = due_words.pop_front();
                    if (o_kind != x.kind || o_seller_id != x.seller ||
                        o_buyer_id != x.buyer || o_trade_item != x.item ||
                        o_trade_price != x.price || o_trade_quantity != x.qty ||
                        o_last != x.last)
                        report_mismatch($sformatf(
                            {"got k%0d s%0d b%0d i%0d p%0d q%0d l%0d",
                             " exp k%0d s%0d b%0d i%0d p%0d q%0d l%0d"},
                            o_kind, o_seller_id, o_buyer_id, o_trade_item, o_trade_price,
                            o_trade_quantity, o_last, x.kind, x.seller, x.buyer, x.item,
                            x.price, x.qty, x.last));
                end
            end
            if (i_valid && o_ready)
                match_order(i_command, i_trader_id, i_item_id, i_limit_price,
                            i_order_quantity);
        end
        pending_words = due_words.size();
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import obm_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_command = 1'b0;
    logic [7:0]  i_trader_id = 8'd0;
    logic [7:0]  i_item_id = 8'd0;
    logic [15:0] i_limit_price = 16'd0;
    logic [15:0] i_order_quantity = 16'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_seller_id;
    logic [7:0]  o_buyer_id;
    logic [7:0]  o_trade_item;
    logic [15:0] o_trade_price;
    logic [15:0] o_trade_quantity;
    logic        o_last;
    int          fail_count;
    int          pending_words;
    bit          stim_done = 1'b0;

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    order_book_matching_unit u_top (.*);
    obm_checker u_chk (.*);

    // Sends one order word and holds it until accepted; gap drawn per word.
    // Valid stays high into the next word when no gap is drawn.
    task automatic send_order(input logic cmd, input logic [7:0] trader,
                              input logic [7:0] item, input logic [15:0] price,
                              input logic [15:0] qty);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_command        <= cmd;
        i_trader_id      <= trader;
        i_item_id        <= item;
        i_limit_price    <= price;
        i_order_quantity <= qty;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Drops valid after the last word and lets the checker see the accept.
    task automatic idle_input();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Receiver: random stall before each word, with stall-free stretches.
    initial begin
        int stall;
        int calm;
        calm = 0;
        @(posedge i_rst_n);
        forever begin
            if (calm > 0) begin
                calm--;
                stall = 0;
            end else if ($urandom_range(0, 40) == 0) begin
                calm = 60;
                stall = 0;
            end else begin
                stall = $urandom_range(0, 16);
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    initial begin
        int n;
        logic [7:0] trd;
        logic [7:0] itm;
        logic [15:0] prc;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, zero quantity, trader zero, crossing edges.
        send_order(1'b0, 8'd255, 8'd0, 16'd0, 16'd0);
        send_order(1'b1, 8'd0, 8'd255, 16'hFFFF, 16'hFFFF);
        send_order(1'b0, 8'd1, 8'd255, 16'hFFFF, 16'd10);   // crosses at equal price
        send_order(1'b0, 8'd0, 8'd255, 16'd5, 16'd1);       // same trader, skipped
        send_order(1'b1, 8'd7, 8'd9, 16'd100, 16'd50);
        send_order(1'b0, 8'd8, 8'd9, 16'd101, 16'd20);      // no cross
        send_order(1'b0, 8'd8, 8'd9, 16'd100, 16'd20);      // equal price cross
        send_order(1'b0, 8'd8, 8'd10, 16'd1, 16'd5);        // other item
        send_order(1'b1, 8'd3, 8'd10, 16'd0, 16'd5);
        send_order(1'b1, 8'd3, 8'd9, 16'd101, 16'hFFFF);    // sweeps partial
        send_order(1'b0, 8'd170, 8'd85, 16'hAAAA, 16'h5555);
        send_order(1'b1, 8'd85, 8'd170, 16'h5555, 16'hAAAA);
        // Fill the sell book to force a drop.
        for (int k = 0; k < 18; k++)
            send_order(1'b0, 8'd40, 8'd200, 16'd60000, 16'd3);
        idle_input();
        wait (pending_words == 0);

        // Random: mostly a small set of traders, items and prices so orders meet.
        n = 0;
        while (n < 350) begin
            if (n == 175) begin
                idle_input();
                wait (pending_words == 0);
                @(posedge i_clk);
            end
            if ($urandom_range(0, 9) < 8) begin
                trd = 8'($urandom_range(0, 5));
                itm = 8'($urandom_range(0, 2));
                prc = 16'(1000 + $urandom_range(0, 20));
                send_order(1'($urandom_range(0, 1)), trd, itm, prc,
                           $urandom_range(0, 9) == 0 ? 16'($urandom) :
                                                       16'($urandom_range(0, 40)));
            end else begin
                send_order(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                           16'($urandom), 16'($urandom));
            end
            n++;
        end
        idle_input();
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        wait (pending_words == 0);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending_words == 0)
            $display("order_book_matching_unit test passed");
        else
            $display("order_book_matching_unit test failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("order_book_matching_unit test failed");
        $finish;
    end

endmodule
